### design/mwo_pkg.sv
// Shared constants, register and waveform codes, and the quarter-wave sine table
// for the multi-waveform oscillator. No dependencies; imported by every design file.
package mwo_pkg;

	localparam int FREQ_W          = 32;
	localparam int PHASE_W         = 32;
	localparam int SAMPLE_W        = 16;
	localparam int ADDR_W          = 4;
	localparam int DATA_W          = 32;

	// quarter-wave table: 2^bits + 1 entries, so the peak has its own entry
	localparam int SINE_TABLE_BITS = 10;
	localparam int SINE_ENTRIES    = (1 << SINE_TABLE_BITS) + 1;
	localparam int SINE_AW         = SINE_TABLE_BITS + 1;

	// register indexes (paddr word offset)
	localparam logic [1:0] REG_WAVEFORM   = 2'd0;
	localparam logic [1:0] REG_USE_MOD    = 2'd1;
	localparam logic [1:0] REG_FIXED_FREQ = 2'd2;
	localparam logic [1:0] REG_RATE_RECIP = 2'd3;

	// waveform select codes
	localparam logic [1:0] WAVE_SAW      = 2'd0;
	localparam logic [1:0] WAVE_SQUARE   = 2'd1;
	localparam logic [1:0] WAVE_TRIANGLE = 2'd2;
	localparam logic [1:0] WAVE_SINE     = 2'd3;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic [SAMPLE_W-1:0] sine_table_t [SINE_ENTRIES];

	// sin(x), x in [0, pi/2] as Q30, by an eight-term Taylor series; Q15 result, capped
	function automatic logic [SAMPLE_W-1:0] sine_q15(input logic [63:0] x);
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        r;
		logic signed [63:0] sum;
		x2   = (x * x) >> 30;
		term = x;
		sum  = signed'(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + signed'(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + signed'(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + signed'(term);
		term = ((term * x2) >> 30) / 64'd210;
		sum  = sum - signed'(term);
		if (sum < 0) begin
			sum = 64'sd0;
		end
		r = (unsigned'(sum) + 64'd16384) >> 15;
		return (r > 64'd32767) ? SAMPLE_MAX : r[SAMPLE_W-1:0];
	endfunction

	// fill the table at elaboration
	function automatic sine_table_t build_sine_table();
		sine_table_t tbl;
		logic [63:0] x;
		for (int k = 0; k < SINE_ENTRIES; k++) begin
			x = (HALF_PI_Q30 * 64'(k) + 64'((1 << SINE_TABLE_BITS) >> 1)) >> SINE_TABLE_BITS;
			tbl[k] = sine_q15(x);
		end
		return tbl;
	endfunction

	localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

### design/mwo_sine_rom.sv
// Quarter-wave sine lookup with a registered read port.
// Depends on mwo_pkg for the table contents and address width.
module mwo_sine_rom (
	input  logic                           clk,
	input  logic                           en,
	input  logic [mwo_pkg::SINE_AW-1:0]    addr,
	output logic [mwo_pkg::SAMPLE_W-1:0]   data
);
	import mwo_pkg::*;

	// register the table entry when the stage advances
	always_ff @(posedge clk) begin
		if (en) begin
			data <= SINE_TABLE[addr];
		end
	end

endmodule

### design/multi_waveform_oscillator_top.sv
// Throughput: one beat per cycle unless sample_stall holds the pipeline. Each beat passes
// the input register, the 32x33 increment multiplier stage, the registered sine table read
// and the output sample register, which together set the depth.
// Reset (arst_n low) clears the config registers, the phase and all stage valids.
// Depends on mwo_pkg and mwo_sine_rom.
module multi_waveform_oscillator_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// config port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [mwo_pkg::ADDR_W-1:0]           paddr,
	input  logic [mwo_pkg::DATA_W-1:0]           pwdata,
	output logic [mwo_pkg::DATA_W-1:0]           prdata,
	output logic                                 pready,
	// frequency channel
	input  logic                                 freq_valid,
	output logic                                 freq_stall,
	input  logic signed [mwo_pkg::FREQ_W-1:0]    modulating_frequency,
	// sample channel
	output logic                                 sample_valid,
	input  logic                                 sample_stall,
	output logic signed [mwo_pkg::SAMPLE_W-1:0]  sample_out
);
	import mwo_pkg::*;

	logic [1:0]                waveform_q;
	logic                      use_mod_q;
	logic signed [FREQ_W-1:0]  fixed_freq_q;
	logic [DATA_W-1:0]         rate_recip_q;
	logic                      cfg_wr;

	logic                      v_s1, v_s2, v_s3, out_v_q;
	logic                      en1, en2, en3, en_out;
	logic signed [FREQ_W-1:0]  freq_s1;
	logic signed [64:0]        prod;
	logic [PHASE_W-1:0]        inc_s2;
	logic [PHASE_W-1:0]        phase_q;
	logic [PHASE_W-1:0]        phase_s3;
	logic [PHASE_W-1:0]        mag_a;
	logic [PHASE_W-1:0]        fold_a;
	logic [SINE_AW-1:0]        rom_addr;
	logic [SAMPLE_W-1:0]       rom_data;
	logic [PHASE_W-1:0]        mag_o;
	logic [16:0]               tri_t;
	logic [SAMPLE_W-1:0]       shaped;
	logic [SAMPLE_W-1:0]       sample_q;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	// write config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q   <= '0;
			use_mod_q    <= 1'b0;
			fixed_freq_q <= '0;
			rate_recip_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_WAVEFORM:   waveform_q   <= pwdata[1:0];
				REG_USE_MOD:    use_mod_q    <= pwdata[0];
				REG_FIXED_FREQ: fixed_freq_q <= pwdata;
				REG_RATE_RECIP: rate_recip_q <= pwdata;
				default:        ;
			endcase
		end
	end

	// read back config registers
	always_comb begin
		unique case (paddr[3:2])
			REG_WAVEFORM:   prdata = {30'd0, waveform_q};
			REG_USE_MOD:    prdata = {31'd0, use_mod_q};
			REG_FIXED_FREQ: prdata = fixed_freq_q;
			REG_RATE_RECIP: prdata = rate_recip_q;
			default:        prdata = '0;
		endcase
	end

	// advance each stage when it is empty or the next one moves
	assign en_out     = !out_v_q || !sample_stall;
	assign en3        = !v_s3 || en_out;
	assign en2        = !v_s2 || en3;
	assign en1        = !v_s1 || en2;
	assign freq_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en1)    v_s1    <= freq_valid;
			if (en2)    v_s2    <= v_s1;
			if (en3)    v_s3    <= v_s2;
			if (en_out) out_v_q <= v_s3;
		end
	end

	// stage 1: select the frequency for this beat
	always_ff @(posedge clk) begin
		if (en1) begin
			freq_s1 <= use_mod_q ? modulating_frequency : fixed_freq_q;
		end
	end

	// stage 2: phase increment = floor(freq * reciprocal / 2^16), low 32 bits
	assign prod = freq_s1 * $signed({1'b0, rate_recip_q});

	always_ff @(posedge clk) begin
		if (en2) begin
			inc_s2 <= prod[47:16];
		end
	end

	// stage 3: take the phase before advancing it, and look up the sine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (en3 && v_s2) begin
			phase_q <= phase_q + inc_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			phase_s3 <= phase_q;
		end
	end

	// fold |phase| into the first quarter wave
	assign mag_a    = phase_q[PHASE_W-1] ? (32'd0 - phase_q) : phase_q;
	assign fold_a   = (mag_a > 32'h4000_0000) ? (32'h8000_0000 - mag_a) : mag_a;
	assign rom_addr = fold_a[30 -: SINE_AW];

	mwo_sine_rom u_sine_rom (
		.clk  (clk),
		.en   (en3),
		.addr (rom_addr),
		.data (rom_data)
	);

	// output stage: shape the phase into the selected waveform
	assign mag_o = phase_s3[PHASE_W-1] ? (32'd0 - phase_s3) : phase_s3;
	assign tri_t = mag_o[31:15];

	always_comb begin
		case (waveform_q)
			WAVE_SAW:      shaped = phase_s3[31:16];
			WAVE_SQUARE:   shaped = (!phase_s3[PHASE_W-1] && (phase_s3 != '0)) ?
			                        SAMPLE_MAX : SAMPLE_MIN;
			WAVE_TRIANGLE: shaped = tri_t[16] ? SAMPLE_MAX : (tri_t[15:0] ^ SAMPLE_MIN);
			WAVE_SINE:     shaped = phase_s3[PHASE_W-1] ? (16'd0 - rom_data) : rom_data;
			default:       shaped = phase_s3[31:16];
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			sample_q <= shaped;
		end
	end

	assign sample_valid = out_v_q;
	assign sample_out   = sample_q;

endmodule

### design/mwo_checker.sv
// Port-level checks for the multi-waveform oscillator, bound to the top level.
// Depends on mwo_pkg for the sample width.
module mwo_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          freq_valid,
	input logic                          freq_stall,
	input logic                          sample_valid,
	input logic                          sample_stall,
	input logic [mwo_pkg::SAMPLE_W-1:0]  sample_out
);
	import mwo_pkg::*;

	logic       in_beat;
	logic       out_beat;
	logic [2:0] pend_q;

	assign in_beat  = freq_valid && !freq_stall;
	assign out_beat = sample_valid && !sample_stall;

	// track beats taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(in_beat) - 3'(out_beat);
		end
	end

	// reset empties the output
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !sample_valid)
		else $error("sample_valid high during reset");

	// a stalled sample beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_stall |=> sample_valid && $stable(sample_out))
		else $error("stalled sample beat changed");

	// no sample without a frequency beat behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid |-> pend_q != 3'd0)
		else $error("sample beat with no frequency beat outstanding");

	// never more beats in flight than pipeline stages
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd4)
		else $error("more beats in flight than stages");

endmodule

bind multi_waveform_oscillator_top mwo_checker u_mwo_checker (.*);
